@@ src/pal_pkg.sv @@
`default_nettype none
package pal_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 7;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_DELETE = 2'd3
  } pal_kind_t;

  typedef struct packed {
    logic      apply;
    pal_kind_t kind;
  } pal_op_t;

endpackage
`default_nettype wire

@@ src/pal_cell.sv @@
`default_nettype none
module pal_cell #(
  parameter int LW  = 7,
  parameter int IDX = 0
) (
  input  wire logic                         clk,
  input  wire pal_pkg::pal_op_t             op,
  input  wire logic [LW-1:0]                idx,
  input  wire logic [LW-1:0]                len,
  input  wire logic [pal_pkg::DATA_W-1:0]   wr_value,
  input  wire logic [pal_pkg::DATA_W-1:0]   left,
  input  wire logic [pal_pkg::DATA_W-1:0]   right,
  output logic      [pal_pkg::DATA_W-1:0]   data
);

  localparam logic [LW-1:0] MY    = LW'(IDX);
  localparam logic [LW-1:0] MY_P1 = LW'(IDX + 1);

  logic [pal_pkg::DATA_W-1:0] data_r;
  logic [pal_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (op.apply) begin
      case (op.kind)
        pal_pkg::KIND_APPEND: begin
          if (len == MY) data_nxt = wr_value;
        end
        pal_pkg::KIND_INSERT: begin
          if (MY == idx) data_nxt = wr_value;
          else if (MY > idx && MY <= len) data_nxt = left;
        end
        pal_pkg::KIND_DELETE: begin
          if (MY >= idx && MY_P1 < len) data_nxt = right;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

@@ src/positional_array_list_core.sv @@
// positional array list: ordered list of up to CAPACITY signed 32-bit words
// held in a row of cells, one word per cell, plus a length register.
// input channel in_*: one request per transaction; in_tuser carries the kind
// (read, append, insert, delete), in_tdata the 1-based position and the word.
// result channel out_*: exactly one result per request; out_tuser is the error
// flag, out_tdata the word read or removed (zero otherwise) and the new length.
// the result is registered and appears on out_* in the cycle after the request is taken.
// throughput: one request per cycle while results are taken; insert and delete
// shift the cells from the position on by one place; a read picks the cell directly.
// a bad position, or append/insert on a full list, flags an error and leaves
// the list untouched.
// reset (rst_n low, synchronous) empties the list and drops any pending result;
// cell contents are left as they are and are never visible before written.
// when the receiver stalls, the pending result holds in the output register and
// in_tready stays low until it is taken; a new request is taken in the same
// cycle the pending result leaves.
`default_nettype none
module positional_array_list_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  input  wire logic [39:0] in_tdata,   // position[6:0], value[38:7], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [0:0]       out_tuser,  // status[0]
  output logic [39:0]      out_tdata   // read_value[31:0], count[38:32], zero pad
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > pal_pkg::POS_W) ? LW : pal_pkg::POS_W) + 1;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  logic                          out_valid_r;
  logic                          status_r;
  logic [pal_pkg::DATA_W-1:0]    rdata_r;
  logic [pal_pkg::CNT_W-1:0]     count_r;
  logic [LW-1:0]                 len_r;

  logic                          out_valid_nxt;
  logic                          status_nxt;
  logic [pal_pkg::DATA_W-1:0]    rdata_nxt;
  logic [pal_pkg::CNT_W-1:0]     count_nxt;
  logic [LW-1:0]                 len_nxt;

  pal_pkg::pal_kind_t            kind;
  logic [pal_pkg::POS_W-1:0]     pos;
  logic [pal_pkg::DATA_W-1:0]    wr_value;
  logic                          accept;
  logic [CW-1:0]                 pos_c;
  logic [CW-1:0]                 len_c;
  logic                          full;
  logic                          in_range;
  logic                          ins_ok;
  logic                          ok;
  logic [LW-1:0]                 idx;
  logic [pal_pkg::DATA_W-1:0]    sel_data;
  pal_pkg::pal_op_t              op;

  logic [pal_pkg::DATA_W-1:0]    cell_data [CAPACITY];

  assign kind     = pal_pkg::pal_kind_t'(in_tuser);
  assign pos      = in_tdata[6:0];
  assign wr_value = in_tdata[38:7];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign pos_c    = CW'(pos);
  assign len_c    = CW'(len_r);
  assign full     = (len_r == CAP_L);
  assign in_range = (pos != '0) && (pos_c <= len_c);
  assign ins_ok   = (pos != '0) && (pos_c <= len_c + CW'(1)) && !full;
  assign idx      = LW'(pos_c - CW'(1));

  always_comb begin
    case (kind)
      pal_pkg::KIND_READ:   ok = in_range;
      pal_pkg::KIND_APPEND: ok = !full;
      pal_pkg::KIND_INSERT: ok = ins_ok;
      pal_pkg::KIND_DELETE: ok = in_range;
      default:              ok = 1'b0;
    endcase
  end

  assign op.apply = accept && ok;
  assign op.kind  = kind;

  // one-hot pick of the addressed cell
  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (idx == LW'(i)) sel_data = sel_data | cell_data[i];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [pal_pkg::DATA_W-1:0] left_w;
    logic [pal_pkg::DATA_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    pal_cell #(
      .LW  (LW),
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .op       (op),
      .idx      (idx),
      .len      (len_r),
      .wr_value (wr_value),
      .left     (left_w),
      .right    (right_w),
      .data     (cell_data[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    rdata_nxt     = rdata_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    if (op.apply) begin
      case (kind)
        pal_pkg::KIND_APPEND: len_nxt = len_r + LW'(1);
        pal_pkg::KIND_INSERT: len_nxt = len_r + LW'(1);
        pal_pkg::KIND_DELETE: len_nxt = len_r - LW'(1);
        default:              len_nxt = len_r;
      endcase
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = !ok;
      rdata_nxt     = (ok && (kind == pal_pkg::KIND_READ || kind == pal_pkg::KIND_DELETE))
                      ? sel_data : '0;
      count_nxt     = pal_pkg::CNT_W'(len_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      len_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rdata_r  <= rdata_nxt;
    count_r  <= count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {1'b0, count_r, rdata_r};

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CAP_L)
    else $error("list length beyond capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r) |-> (rdata_r == '0))
    else $error("error result carries a value");

  a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && kind == pal_pkg::KIND_APPEND && !full) |=> (len_r == $past(len_r) + LW'(1)))
    else $error("append did not grow the list");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (count_r == pal_pkg::CNT_W'(len_r)))
    else $error("reported count differs from list length");
`endif

endmodule
`default_nettype wire

@@ sim/tb_positional_array_list_core.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_positional_array_list_core;

  localparam int CAPACITY    = 64;
  localparam int QUIET_LIMIT = 1000;
  localparam int BLOCK_ITEMS = 110;
  localparam int NUM_BLOCKS  = 14;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum int {MODE_GROW, MODE_MIXED, MODE_SHRINK} traffic_mode_t;

  typedef struct {
    logic        status;
    logic [31:0] word;
    logic [6:0]  count;
  } list_reply_t;

  class array_list_mirror;
    logic [31:0] cells[CAPACITY];
    int          used;
    int          errors;
    list_reply_t replies[$];

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    function void note_request(pal_pkg::pal_kind_t kind, logic [6:0] pos, logic [31:0] value);
      list_reply_t r;
      int          p;
      p = int'(pos);
      r = '{STATUS_ERR, 32'd0, 7'd0};
      case (kind)
        pal_pkg::KIND_READ: begin
          if (p >= 1 && p <= used) begin
            r.status = STATUS_OK;
            r.word   = cells[p - 1];
          end
        end
        pal_pkg::KIND_APPEND: begin
          if (used < CAPACITY) begin
            cells[used] = value;
            used++;
            r.status = STATUS_OK;
          end
        end
        pal_pkg::KIND_INSERT: begin
          if (p >= 1 && p <= used + 1 && used < CAPACITY) begin
            for (int i = used; i >= p; i--) cells[i] = cells[i - 1];
            cells[p - 1] = value;
            used++;
            r.status = STATUS_OK;
          end
        end
        default: begin
          if (p >= 1 && p <= used) begin
            r.word = cells[p - 1];
            for (int i = p; i < used; i++) cells[i - 1] = cells[i];
            used--;
            r.status = STATUS_OK;
          end
        end
      endcase
      r.count = used[6:0];
      replies.push_back(r);
    endfunction

    function void check_result(logic status, logic [31:0] word, logic [6:0] count);
      list_reply_t e;
      if (replies.size() == 0) begin
        $error("result transaction with no request outstanding");
        errors++;
        return;
      end
      e = replies.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (word !== e.word) begin
        $error("read_value: expected %0d, got %0d", $signed(e.word), $signed(word));
        errors++;
      end
      if (count !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = '0;  // kind[1:0]
  logic [39:0] in_tdata   = '0;  // position[6:0], value[38:7], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [0:0]  out_tuser;        // status[0]
  logic [39:0] out_tdata;        // read_value[31:0], count[38:32], zero pad

  array_list_mirror mirror = new();
  bit idle_on = 1'b1;
  int quiet   = 0;
  bit moved;

  always #2 clk = ~clk;

  positional_array_list_core #(
    .CAPACITY (CAPACITY)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        mirror.check_result(out_tuser[0], out_tdata[31:0], out_tdata[38:32]);
        moved = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        mirror.note_request(pal_pkg::pal_kind_t'(in_tuser), in_tdata[6:0], in_tdata[38:7]);
        moved = 1'b1;
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_positional_array_list_core: done, errors");
        $finish;
      end
    end
  end

  // receiver stalls
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_request(pal_pkg::pal_kind_t kind, logic [6:0] pos, logic [31:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, value, pos};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  function automatic pal_pkg::pal_kind_t pick_kind(traffic_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:
        return r < 40 ? pal_pkg::KIND_APPEND :
               r < 70 ? pal_pkg::KIND_INSERT :
               r < 90 ? pal_pkg::KIND_READ : pal_pkg::KIND_DELETE;
      MODE_SHRINK:
        return r < 50 ? pal_pkg::KIND_DELETE :
               r < 75 ? pal_pkg::KIND_READ :
               r < 85 ? pal_pkg::KIND_APPEND : pal_pkg::KIND_INSERT;
      default:
        return pal_pkg::pal_kind_t'(r / 25);
    endcase
  endfunction

  function automatic logic [6:0] pick_position(pal_pkg::pal_kind_t kind, int len);
    int top;
    top = (kind == pal_pkg::KIND_INSERT) ? len + 1 : len;
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'($urandom_range(0, 127));
      2: return 7'(len + 1);
      3: return 7'd1;
      4: return 7'(top);
      default: return (top == 0) ? 7'd1 : 7'($urandom_range(1, top));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    traffic_mode_t      mode;
    pal_pkg::pal_kind_t kind;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty list rejects
    send_request(pal_pkg::KIND_READ,   7'd0, 32'h1111_1111);
    send_request(pal_pkg::KIND_READ,   7'd1, 32'h0);
    send_request(pal_pkg::KIND_DELETE, 7'd1, 32'h0);
    send_request(pal_pkg::KIND_INSERT, 7'd0, 32'h2222_2222);
    send_request(pal_pkg::KIND_INSERT, 7'd2, 32'h3333_3333);
    // build a short list
    send_request(pal_pkg::KIND_INSERT, 7'd1, 32'h7fff_ffff);
    send_request(pal_pkg::KIND_APPEND, 7'd0, 32'h8000_0000);
    send_request(pal_pkg::KIND_APPEND, 7'd9, 32'h0);
    send_request(pal_pkg::KIND_INSERT, 7'd4, 32'hffff_ffff);
    send_request(pal_pkg::KIND_INSERT, 7'd2, 32'h1234_5678);
    send_request(pal_pkg::KIND_READ,   7'd1, 32'h0);
    send_request(pal_pkg::KIND_READ,   7'd5, 32'hdead_beef);
    // positions past the end
    send_request(pal_pkg::KIND_READ,   7'd6, 32'h0);
    send_request(pal_pkg::KIND_READ,   7'd127, 32'h0);
    send_request(pal_pkg::KIND_DELETE, 7'd127, 32'h0);
    send_request(pal_pkg::KIND_DELETE, 7'd6, 32'h0);
    send_request(pal_pkg::KIND_INSERT, 7'd7, 32'h4444_4444);
    send_request(pal_pkg::KIND_INSERT, 7'd127, 32'h5555_5555);
    // delete middle, last and first
    send_request(pal_pkg::KIND_DELETE, 7'd3, 32'h0);
    send_request(pal_pkg::KIND_DELETE, 7'd4, 32'h0);
    send_request(pal_pkg::KIND_DELETE, 7'd1, 32'h0);
    send_request(pal_pkg::KIND_READ,   7'd2, 32'h0);
    send_request(pal_pkg::KIND_APPEND, 7'd127, 32'h5555_aaaa);
    send_request(pal_pkg::KIND_DELETE, 7'd0, 32'h0);

    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      case (blk % 4)
        0:       mode = MODE_GROW;
        2:       mode = MODE_SHRINK;
        default: mode = MODE_MIXED;
      endcase
      idle_on = (blk < NUM_BLOCKS - 2) && ($urandom_range(0, 3) != 0);
      if (blk == 5) drain_replies();
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        kind = pick_kind(mode);
        send_request(kind, pick_position(kind, mirror.used), pick_value());
      end
    end

    in_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("tb_positional_array_list_core: done, clean");
    end else begin
      if (mirror.pending() != 0) $error("%0d results never arrived", mirror.pending());
      $display("tb_positional_array_list_core: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
